// ----- rtl/tvcs_pkg.sv -----
`timescale 1ns / 1ps
package tvcs_pkg;

  // Default depth of the filling-duration table
  localparam int FILL_DEPTH_DEF = 8;

  // Register reset values
  localparam logic [9:0] MAX_RUNS_RST   = 10'd599;
  localparam logic [3:0] FILL_COUNT_RST = 4'd1;

  // Result item width: rv_detection, cv_open, valve_changed, run_number, finished
  localparam int RES_W = 15;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_CLEAN = 3'd0;
  localparam logic [2:0] REG_DAQ_CLEAN   = 3'd1;
  localparam logic [2:0] REG_PREPARE     = 3'd2;
  localparam logic [2:0] REG_STORAGE     = 3'd3;
  localparam logic [2:0] REG_MAX_RUNS    = 3'd4;
  localparam logic [2:0] REG_FILL_COUNT  = 3'd5;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CLEAN = 3'd1,
    PH_FILL  = 3'd2,
    PH_PREP  = 3'd3,
    PH_STORE = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic [31:0] first_clean_ticks;
    logic [31:0] daq_clean_ticks;
    logic [31:0] prepare_ticks;
    logic [31:0] storage_ticks;
    logic [9:0]  max_runs;
    logic [3:0]  fill_count;
  } cfg_t;

endpackage

// ----- rtl/tvcs_ram.sv -----
`timescale 1ns / 1ps
module tvcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tvcs_fill_table.sv -----
`timescale 1ns / 1ps
module tvcs_fill_table #(
  parameter int FILL_DEPTH = tvcs_pkg::FILL_DEPTH_DEF,
  localparam int PW = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [PW-1:0] rd_addr,   // position for the next cycle
  output logic [31:0]   rd_data    // duration at the current position
);

  logic [FILL_DEPTH-1:0] valid_r, valid_nxt;
  logic [PW-1:0]         rd_addr_r;
  logic                  byp_r;
  logic [31:0]           byp_data_r;
  logic [31:0]           ram_q;

  tvcs_ram #(
    .WIDTH (32),
    .DEPTH (FILL_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Mark written entries; unwritten ones read as zero
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      byp_r   <= wr_en && (wr_addr == rd_addr);
    end
    rd_addr_r  <= rd_addr;
    byp_data_r <= wr_data;
  end

  // Forward a write that lands on the entry being read
  assign rd_data = byp_r              ? byp_data_r :
                   valid_r[rd_addr_r] ? ram_q      : 32'd0;

endmodule

// ----- rtl/tvcs_cfg.sv -----
`timescale 1ns / 1ps
module tvcs_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data,
  output tvcs_pkg::cfg_t cfg
);
  import tvcs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_FIRST_CLEAN: cfg_nxt.first_clean_ticks = wr_data;
        REG_DAQ_CLEAN:   cfg_nxt.daq_clean_ticks   = wr_data;
        REG_PREPARE:     cfg_nxt.prepare_ticks     = wr_data;
        REG_STORAGE:     cfg_nxt.storage_ticks     = wr_data;
        REG_MAX_RUNS:    cfg_nxt.max_runs          = wr_data[9:0];
        REG_FILL_COUNT:  cfg_nxt.fill_count        = wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_clean_ticks <= '0;
      cfg_r.daq_clean_ticks   <= '0;
      cfg_r.prepare_ticks     <= '0;
      cfg_r.storage_ticks     <= '0;
      cfg_r.max_runs          <= MAX_RUNS_RST;
      cfg_r.fill_count        <= FILL_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/tvcs_out_skid.sv -----
`timescale 1ns / 1ps
module tvcs_out_skid (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [tvcs_pkg::RES_W-1:0] push_data,
  output logic                       push_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tvcs_pkg::RES_W-1:0] out_data
);
  import tvcs_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [RES_W-1:0] out_data_r, out_data_nxt;
  logic [RES_W-1:0] skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop = out_valid_r && out_ready;

  // Refill the output stage from the skid stage or take the new item
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

// ----- rtl/timed_valve_cycle_sequencer.sv -----
`timescale 1ns / 1ps
// Each accepted command pushes one result item into the registered output stage.
// Throughput: one command per cycle while in_tready is high; the phase update is a
// single compare of the elapsed-tick counter against the current phase duration.
// A two-entry output stage keeps in_tready high while one result waits.
// Reset (synchronous, rst_n low): phase idle, counters zero, valves filling/closed,
// registers to defaults, table entries read as zero until written.
module timed_valve_cycle_sequencer #(
  parameter int FILL_DEPTH = tvcs_pkg::FILL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input commands
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // fill_index[2:0], fill_ticks[34:3], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // rv_detection[0], cv_open[1], valve_changed[2],
                                  // run_number[13:3], finished[14], zero pad
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tvcs_pkg::*;

  localparam int PW = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
  localparam int CW = ($clog2(FILL_DEPTH + 1) > 4) ? $clog2(FILL_DEPTH + 1) : 4;

  cfg_t        cfg;
  logic        accept;
  cmd_t        cmd;
  logic [2:0]  fill_index;
  logic [31:0] fill_ticks;

  phase_t      phase_r, phase_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [10:0] runs_r, runs_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [1:0]  valve_r, valve_nxt;
  logic        changed;

  logic        tbl_wr_en;
  logic [PW-1:0] tbl_rd_addr;
  logic [31:0] fill_dur;
  logic [31:0] store_limit;
  logic [31:0] limit;
  logic [31:0] el_inc;
  logic [CW-1:0] cnt_use;
  logic [CW-1:0] pos_inc;
  logic [RES_W-1:0] res;

  assign cmd        = cmd_t'(in_tuser);
  assign fill_index = in_tdata[2:0];
  assign fill_ticks = in_tdata[34:3];
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  tvcs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Table writes beyond the depth are dropped
  assign tbl_wr_en   = accept && (cmd == CMD_WRITE) && (32'(fill_index) < 32'(FILL_DEPTH));
  assign tbl_rd_addr = rst_n ? pos_nxt : '0;

  tvcs_fill_table #(
    .FILL_DEPTH (FILL_DEPTH)
  ) u_fill_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (PW'(fill_index)),
    .wr_data (fill_ticks),
    .rd_addr (tbl_rd_addr),
    .rd_data (fill_dur)
  );

  // Duration of the current phase
  assign store_limit = (cfg.storage_ticks > cfg.prepare_ticks) ?
                       (cfg.storage_ticks - cfg.prepare_ticks) : 32'd0;

  always_comb begin
    unique case (phase_r)
      PH_CLEAN: limit = (runs_r == 11'd0) ? cfg.first_clean_ticks : cfg.daq_clean_ticks;
      PH_FILL:  limit = fill_dur;
      PH_PREP:  limit = cfg.prepare_ticks;
      default:  limit = store_limit;
    endcase
  end

  // Entries in use, clamped to one and to the table depth
  always_comb begin
    if (cfg.fill_count == 4'd0) begin
      cnt_use = CW'(1);
    end else if (CW'(cfg.fill_count) > CW'(FILL_DEPTH)) begin
      cnt_use = CW'(FILL_DEPTH);
    end else begin
      cnt_use = CW'(cfg.fill_count);
    end
  end

  assign pos_inc = CW'(pos_r) + CW'(1);
  assign el_inc  = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;

  // Advance the sequence on each accepted command
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    runs_nxt    = runs_r;
    pos_nxt     = pos_r;
    valve_nxt   = valve_r;
    changed     = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          phase_nxt   = PH_CLEAN;
          elapsed_nxt = '0;
          runs_nxt    = '0;
          pos_nxt     = '0;
          valve_nxt   = 2'b11;
          changed     = 1'b1;
        end
        CMD_TICK: begin
          if (phase_r == PH_CLEAN || phase_r == PH_FILL ||
              phase_r == PH_PREP  || phase_r == PH_STORE) begin
            elapsed_nxt = el_inc;
            if (el_inc >= limit) begin
              elapsed_nxt = '0;
              changed     = 1'b1;
              unique case (phase_r)
                PH_CLEAN: begin
                  runs_nxt = runs_r + 11'd1;
                  if (runs_nxt > {1'b0, cfg.max_runs}) begin
                    valve_nxt = 2'b00;
                    phase_nxt = PH_DONE;
                  end else begin
                    valve_nxt = 2'b01;
                    phase_nxt = PH_FILL;
                  end
                end
                PH_FILL: begin
                  valve_nxt = 2'b00;
                  phase_nxt = PH_PREP;
                end
                PH_PREP: begin
                  valve_nxt = 2'b10;
                  phase_nxt = PH_STORE;
                end
                default: begin
                  valve_nxt = 2'b11;
                  phase_nxt = PH_CLEAN;
                  pos_nxt   = (pos_inc >= cnt_use) ? '0 : PW'(pos_inc);
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      runs_r    <= '0;
      pos_r     <= '0;
      valve_r   <= 2'b00;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      runs_r    <= runs_nxt;
      pos_r     <= pos_nxt;
      valve_r   <= valve_nxt;
    end
  end

  // Pack the result item from the updated state
  assign res = {(phase_nxt == PH_DONE), runs_nxt, changed, valve_nxt[0], valve_nxt[1]};

  tvcs_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata[RES_W-1:0])
  );

  assign out_tdata[15:RES_W] = '0;

endmodule

// ----- sim/valve_sequence_checker.sv -----
`timescale 1ns / 1ps
module valve_sequence_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // fill_index[2:0], fill_ticks[34:3], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // rv_detection[0], cv_open[1], valve_changed[2],
                                  // run_number[13:3], finished[14], zero pad
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import tvcs_pkg::*;

  localparam int TABLE_DEPTH = FILL_DEPTH_DEF;

  // Valve positions: bit 1 rotary valve in detection, bit 0 cell valve open
  localparam logic [1:0] VALVES_FILL_CLOSED = 2'b00;
  localparam logic [1:0] VALVES_FILL_OPEN   = 2'b01;
  localparam logic [1:0] VALVES_DET_CLOSED  = 2'b10;
  localparam logic [1:0] VALVES_DET_OPEN    = 2'b11;

  // Result item as laid out on out_tdata, lowest field last
  typedef struct packed {
    logic        finished;
    logic [10:0] run_number;
    logic        valve_changed;
    logic        cv_open;
    logic        rv_detection;
  } valve_report_t;

  // Model copy of registers and sequencer state
  cfg_t          timing;
  phase_t        phase;
  logic [31:0]   elapsed;
  logic [10:0]   runs_done;
  logic [2:0]    table_pos;
  logic [31:0]   fill_table [TABLE_DEPTH];
  logic [1:0]    valve_bits;
  valve_report_t expected_reports [$];
  int            mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [3:0] entries_in_use();
    logic [3:0] n;
    n = timing.fill_count;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(TABLE_DEPTH)) n = 4'(TABLE_DEPTH);
    return n;
  endfunction

  // Duration of the phase in progress, from the registers as they stand now
  function automatic logic [31:0] phase_duration();
    case (phase)
      PH_CLEAN: return (runs_done == 11'd0) ? timing.first_clean_ticks
                                             : timing.daq_clean_ticks;
      PH_FILL:  return fill_table[table_pos];
      PH_PREP:  return timing.prepare_ticks;
      default:  return (timing.storage_ticks > timing.prepare_ticks)
                       ? timing.storage_ticks - timing.prepare_ticks : 32'd0;
    endcase
  endfunction

  // Apply one command to the model and form the result item it causes
  task automatic apply_command(input logic [1:0] code, input logic [2:0] idx,
                               input logic [31:0] ticks, output valve_report_t rep);
    logic changed;
    changed = 1'b0;
    case (cmd_t'(code))
      CMD_START: begin
        phase      = PH_CLEAN;
        elapsed    = '0;
        runs_done  = '0;
        table_pos  = '0;
        valve_bits = VALVES_DET_OPEN;
        changed    = 1'b1;
      end
      CMD_WRITE: fill_table[idx] = ticks;
      CMD_TICK: begin
        if (phase >= PH_CLEAN && phase <= PH_STORE) begin
          if (elapsed != '1) elapsed = elapsed + 32'd1;
          if (elapsed >= phase_duration()) begin
            elapsed = '0;
            changed = 1'b1;
            case (phase)
              PH_CLEAN: begin
                runs_done  = runs_done + 11'd1;
                valve_bits = VALVES_FILL_OPEN;
                phase      = PH_FILL;
                // Past the last run: shut the valves and stop
                if (runs_done > {1'b0, timing.max_runs}) begin
                  valve_bits = VALVES_FILL_CLOSED;
                  phase      = PH_DONE;
                end
              end
              PH_FILL: begin
                valve_bits = VALVES_FILL_CLOSED;
                phase      = PH_PREP;
              end
              PH_PREP: begin
                valve_bits = VALVES_DET_CLOSED;
                phase      = PH_STORE;
              end
              default: begin
                // Release: open the cell and advance the table position cyclically
                valve_bits = VALVES_DET_OPEN;
                phase      = PH_CLEAN;
                if ({1'b0, table_pos} + 4'd1 >= entries_in_use()) table_pos = '0;
                else table_pos = table_pos + 3'd1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    rep.rv_detection  = valve_bits[1];
    rep.cv_open       = valve_bits[0];
    rep.valve_changed = changed;
    rep.run_number    = runs_done;
    rep.finished      = (phase == PH_DONE);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    valve_report_t got;
    valve_report_t want;
    valve_report_t rep;
    if (!rst_n) begin
      timing = '{first_clean_ticks: '0, daq_clean_ticks: '0, prepare_ticks: '0,
                 storage_ticks: '0, max_runs: MAX_RUNS_RST, fill_count: FILL_COUNT_RST};
      phase      = PH_IDLE;
      elapsed    = '0;
      runs_done  = '0;
      table_pos  = '0;
      valve_bits = VALVES_FILL_CLOSED;
      foreach (fill_table[i]) fill_table[i] = '0;
      expected_reports.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_CLEAN: timing.first_clean_ticks = cfg_data;
          REG_DAQ_CLEAN:   timing.daq_clean_ticks   = cfg_data;
          REG_PREPARE:     timing.prepare_ticks     = cfg_data;
          REG_STORAGE:     timing.storage_ticks     = cfg_data;
          REG_MAX_RUNS:    timing.max_runs          = cfg_data[9:0];
          REG_FILL_COUNT:  timing.fill_count        = cfg_data[3:0];
          default: ;
        endcase
      end
      // Compare each result item with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = valve_report_t'(out_tdata[14:0]);
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: result item %h expected none", $time, got);
        end else begin
          want = expected_reports.pop_front();
          check_field("rv_detection", want.rv_detection, got.rv_detection);
          check_field("cv_open", want.cv_open, got.cv_open);
          check_field("valve_changed", want.valve_changed, got.valve_changed);
          check_field("run_number", want.run_number, got.run_number);
          check_field("finished", want.finished, got.finished);
        end
      end
      // Predict the result of each accepted command
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata[2:0], in_tdata[34:3], rep);
        expected_reports.push_back(rep);
      end
    end
    pending <= expected_reports.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import tvcs_pkg::*;

  // Codes the block must ignore
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int LIMIT_CYCLES      = 200000;
  localparam int RANDOM_SEGMENTS   = 8;
  localparam int ITEMS_PER_SEGMENT = 70;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycles = 0;

  always #2 clk = ~clk;

  timed_valve_cycle_sequencer dut (.*);

  valve_sequence_checker valve_check (.*);

  // Receiver: stall at the rate of the current segment
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one command, idling first at the sender's rate, and hold it until taken
  task automatic send_command(input logic [1:0] code, input logic [2:0] idx,
                              input logic [31:0] ticks);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {5'd0, ticks, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and hold until every result item has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register, plus one spare index; junk goes in the unused upper bits
  task automatic load_timing(input logic [31:0] first_clean, input logic [31:0] daq_clean,
                             input logic [31:0] prepare, input logic [31:0] storage,
                             input logic [9:0] runs_max, input logic [3:0] entries);
    logic [31:0] word;
    write_register(REG_FIRST_CLEAN, first_clean);
    write_register(REG_DAQ_CLEAN, daq_clean);
    write_register(REG_PREPARE, prepare);
    write_register(REG_STORAGE, storage);
    word = $urandom();
    word[9:0] = runs_max;
    write_register(REG_MAX_RUNS, word);
    word = $urandom();
    word[3:0] = entries;
    write_register(REG_FILL_COUNT, word);
    write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
  endtask

  // Mostly short durations so the cycle keeps turning over, now and then a huge one
  function automatic logic [31:0] pick_duration();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 4));
  endfunction

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 84)
      send_command(CMD_TICK, 3'($urandom()), $urandom());
    else if (pick < 89)
      send_command(CMD_START, 3'($urandom()), $urandom());
    else if (pick < 97)
      send_command(CMD_WRITE, 3'($urandom_range(0, 7)),
                   ($urandom_range(0, 19) == 0) ? 32'($urandom())
                                                : 32'($urandom_range(0, 5)));
    else
      send_command(CMD_UNUSED, 3'($urandom()), $urandom());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Endless waits, table count above depth, highest run limit
    load_timing('1, '1, '1, '0, 10'd1023, 4'd15);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_UNUSED, 3'd7, '1);
    send_command(CMD_WRITE, 3'd7, '1);
    send_command(CMD_WRITE, 3'd0, '0);
    send_command(CMD_START, 3'd0, '0);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_START, 3'd0, '0);
    wait_idle();

    // Zero waits, run limit zero, table count zero: finish on the first run
    load_timing('0, '0, '0, '0, 10'd0, 4'd0);
    send_command(CMD_START, 3'd0, '0);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TICK, 3'd0, '0);
    wait_idle();

    // Storage shorter than prepare, two table entries, two runs then finish
    load_timing(32'd1, 32'd0, 32'd2, 32'd1, 10'd2, 4'd2);
    send_command(CMD_WRITE, 3'd0, 32'd1);
    send_command(CMD_START, 3'd0, '0);
    repeat (12) send_command(CMD_TICK, 3'd0, '0);
    wait_idle();

    // Random segments across the idling modes
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
      endcase
      load_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                  ($urandom_range(0, 5) == 0) ? 10'd1023 : 10'($urandom_range(0, 4)),
                  4'($urandom_range(0, 15)));
      for (int e = 0; e < FILL_DEPTH_DEF; e++)
        send_command(CMD_WRITE, 3'(e), $urandom_range(0, 4));
      send_command(CMD_START, 3'd0, '0);
      repeat (ITEMS_PER_SEGMENT) send_random_item();
      wait_idle();
    end

    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- timed_valve_cycle_sequencer.f -----
rtl/tvcs_pkg.sv
rtl/tvcs_ram.sv
rtl/tvcs_fill_table.sv
rtl/tvcs_cfg.sv
rtl/tvcs_out_skid.sv
rtl/timed_valve_cycle_sequencer.sv
sim/valve_sequence_checker.sv
sim/tb_top.sv
